FILE: src/sma_pkg.sv
// ----------------------------------------------------------------------------
// Sign-magnitude accumulator ALU package
// Shared constants, opcodes and the sequencer state type.
// ----------------------------------------------------------------------------
package sma_pkg;

   localparam int MAGNITUDE_BITS = 14;
   localparam int ACTION_BITS    = 7;

   localparam logic [ACTION_BITS-1:0] OP_ADD = 7'h1E;
   localparam logic [ACTION_BITS-1:0] OP_SUB = 7'h1F;
   localparam logic [ACTION_BITS-1:0] OP_DIV = 7'h20;
   localparam logic [ACTION_BITS-1:0] OP_MUL = 7'h21;
   localparam logic [ACTION_BITS-1:0] OP_NOT = 7'h33;
   localparam logic [ACTION_BITS-1:0] OP_AND = 7'h34;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SWAP,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } sma_state_type;

endpackage

FILE: src/sma_if.sv
// ----------------------------------------------------------------------------
// Sign-magnitude accumulator ALU channels
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface sma_req_if #(
   parameter int MagBits = sma_pkg::MAGNITUDE_BITS
);
   logic                           valid;
   logic                           ready;
   logic [sma_pkg::ACTION_BITS-1:0] action;
   logic [MagBits:0]               memory_word;

   modport source (output valid, action, memory_word, input ready);
   modport sink   (input valid, action, memory_word, output ready);
endinterface

interface sma_rsp_if #(
   parameter int MagBits = sma_pkg::MAGNITUDE_BITS
);
   logic             valid;
   logic             ready;
   logic [MagBits:0] acc_result;
   logic             divide_by_zero;
   logic             halt_clock;
   logic             unknown_command;
   logic             overflow;

   modport source (output valid, acc_result, divide_by_zero, halt_clock,
                   unknown_command, overflow, input ready);
   modport sink   (input valid, acc_result, divide_by_zero, halt_clock,
                   unknown_command, overflow, output ready);
endinterface

FILE: src/sign_magnitude_accumulator_alu_unit.sv
// ----------------------------------------------------------------------------
// Sign-magnitude accumulator ALU
// NOT, AND and error cases go straight to the commit state; add and subtract
// pass through ST_ADD and, on a borrow, ST_SWAP; multiply and divide iterate
// ST_MUL or ST_DIV, one radix-2 step per cycle through the shared adder.
// One item at a time; a new item is taken the cycle after the result is
// committed.
// Synchronous reset clears the accumulator and the sequencer.
// ----------------------------------------------------------------------------
module sign_magnitude_accumulator_alu_unit #(
   parameter int MAGNITUDE_BITS = sma_pkg::MAGNITUDE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   sma_req_if.sink    req_port,
   sma_rsp_if.source  rsp_port
);

   localparam int M        = MAGNITUDE_BITS;
   localparam int CntBits  = $clog2(MAGNITUDE_BITS);

   sma_pkg::sma_state_type state_ff, state_in;

   logic [M:0]         acc_ff, acc_in;
   logic [M:0]         res_ff, res_in;
   logic               res_dz_ff, res_dz_in;
   logic               res_unk_ff, res_unk_in;
   logic               res_ovf_ff, res_ovf_in;
   logic [M-1:0]       mb_ff, mb_in;
   logic               sb_ff, sb_in;
   logic [M-1:0]       hi_ff, hi_in;
   logic [M-1:0]       lo_ff, lo_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_dz_ff, rsp_dz_in;
   logic               rsp_unk_ff, rsp_unk_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [M:0]   add_a, add_b;
   logic         add_sub;
   logic [M+1:0] add_sum;

   logic         req_fire;
   logic         slot_free;
   logic         last_step;
   logic         word_zero;
   logic [M:0]   mul_sum;
   logic [M-1:0] mul_hi, mul_lo;
   logic         div_ge;
   logic [M-1:0] div_rem, div_q;

   sma_addsub #(.Width(M + 1)) u_addsub (
      .op_a     (add_a),
      .op_b     (add_b),
      .subtract (add_sub),
      .sum      (add_sum)
   );

   assign req_port.ready = (state_ff == sma_pkg::ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign slot_free      = !rsp_valid_ff || rsp_port.ready;
   assign last_step      = (cnt_ff == CntBits'(M - 1));
   assign word_zero      = (req_port.memory_word[M-1:0] == '0);

   // Multiply step: conditional add of the memory operand, then shift.
   assign mul_sum = lo_ff[0] ? add_sum[M:0] : {1'b0, hi_ff};
   assign mul_hi  = mul_sum[M:1];
   assign mul_lo  = {mul_sum[0], lo_ff[M-1:1]};

   // Restoring divide step: the carry out says the trial subtract fit.
   assign div_ge  = add_sum[M+1];
   assign div_rem = div_ge ? add_sum[M-1:0] : add_a[M-1:0];
   assign div_q   = {lo_ff[M-2:0], div_ge};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sma_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_port.action)
                  sma_pkg::OP_ADD,
                  sma_pkg::OP_SUB: state_in = sma_pkg::ST_ADD;
                  sma_pkg::OP_MUL: state_in = sma_pkg::ST_MUL;
                  sma_pkg::OP_DIV: state_in = word_zero ? sma_pkg::ST_FINISH
                                                        : sma_pkg::ST_DIV;
                  default:         state_in = sma_pkg::ST_FINISH;
               endcase
            end
         end
         sma_pkg::ST_ADD: begin
            if (add_sub && !add_sum[M+1]) begin
               state_in = sma_pkg::ST_SWAP;
            end else begin
               state_in = sma_pkg::ST_FINISH;
            end
         end
         sma_pkg::ST_SWAP: state_in = sma_pkg::ST_FINISH;
         sma_pkg::ST_MUL,
         sma_pkg::ST_DIV: begin
            if (last_step) begin
               state_in = sma_pkg::ST_FINISH;
            end
         end
         sma_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = sma_pkg::ST_IDLE;
            end
         end
         default: state_in = sma_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      acc_in       = acc_ff;
      res_in       = res_ff;
      res_dz_in    = res_dz_ff;
      res_unk_in   = res_unk_ff;
      res_ovf_in   = res_ovf_ff;
      mb_in        = mb_ff;
      sb_in        = sb_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_dz_in    = rsp_dz_ff;
      rsp_unk_in   = rsp_unk_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      add_a        = {1'b0, acc_ff[M-1:0]};
      add_b        = {1'b0, mb_ff};
      add_sub      = 1'b0;

      unique case (state_ff)
         sma_pkg::ST_IDLE: begin
            if (req_fire) begin
               mb_in      = req_port.memory_word[M-1:0];
               sb_in      = req_port.memory_word[M] ^ (req_port.action == sma_pkg::OP_SUB);
               hi_in      = '0;
               lo_in      = acc_ff[M-1:0];
               cnt_in     = '0;
               res_in     = acc_ff;
               res_dz_in  = 1'b0;
               res_unk_in = 1'b0;
               res_ovf_in = 1'b0;
               unique case (req_port.action)
                  sma_pkg::OP_ADD,
                  sma_pkg::OP_SUB,
                  sma_pkg::OP_MUL: ;
                  sma_pkg::OP_DIV: res_dz_in = word_zero;
                  sma_pkg::OP_NOT: res_in = ~acc_ff;
                  sma_pkg::OP_AND: res_in = acc_ff & req_port.memory_word;
                  default: begin
                     res_dz_in  = 1'b1;
                     res_unk_in = 1'b1;
                  end
               endcase
            end
         end
         sma_pkg::ST_ADD: begin
            // Unlike signs turn into a magnitude subtract; a borrow means the
            // operands must be swapped in the next cycle.
            add_sub    = acc_ff[M] ^ sb_ff;
            res_in     = {acc_ff[M] && (add_sum[M:0] != '0), add_sum[M-1:0]};
            res_ovf_in = !add_sub && add_sum[M];
         end
         sma_pkg::ST_SWAP: begin
            add_a   = {1'b0, mb_ff};
            add_b   = {1'b0, acc_ff[M-1:0]};
            add_sub = 1'b1;
            res_in  = {sb_ff, add_sum[M-1:0]};
         end
         sma_pkg::ST_MUL: begin
            add_a  = {1'b0, hi_ff};
            hi_in  = mul_hi;
            lo_in  = mul_lo;
            cnt_in = cnt_ff + 1'b1;
            if (last_step) begin
               res_in     = {(acc_ff[M] ^ sb_ff) && ({mul_hi, mul_lo} != '0), mul_lo};
               res_ovf_in = (mul_hi != '0);
            end
         end
         sma_pkg::ST_DIV: begin
            add_a   = {hi_ff, lo_ff[M-1]};
            add_sub = 1'b1;
            hi_in   = div_rem;
            lo_in   = div_q;
            cnt_in  = cnt_ff + 1'b1;
            if (last_step) begin
               res_in = {(acc_ff[M] ^ sb_ff) && (div_q != '0), div_q};
            end
         end
         sma_pkg::ST_FINISH: begin
            if (slot_free) begin
               acc_in       = res_ff;
               rsp_valid_in = 1'b1;
               rsp_dz_in    = res_dz_ff;
               rsp_unk_in   = res_unk_ff;
               rsp_ovf_in   = res_ovf_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sma_pkg::ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff     <= res_in;
      res_dz_ff  <= res_dz_in;
      res_unk_ff <= res_unk_in;
      res_ovf_ff <= res_ovf_in;
      mb_ff      <= mb_in;
      sb_ff      <= sb_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      cnt_ff     <= cnt_in;
      rsp_dz_ff  <= rsp_dz_in;
      rsp_unk_ff <= rsp_unk_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // The result item shows the committed accumulator directly.
   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.acc_result      = acc_ff;
   assign rsp_port.divide_by_zero  = rsp_dz_ff;
   assign rsp_port.halt_clock      = rsp_dz_ff;
   assign rsp_port.unknown_command = rsp_unk_ff;
   assign rsp_port.overflow        = rsp_ovf_ff;

   a_commit_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sma_pkg::ST_FINISH && slot_free)
      |=> (rsp_valid_ff && acc_ff == $past(res_ff)))
      else $error("committed accumulator does not match the computed result");

   a_error_keeps_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sma_pkg::ST_FINISH && res_dz_ff) |-> (res_ff == acc_ff))
      else $error("an error item changed the accumulator");

   a_unknown_implies_halt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sma_pkg::ST_FINISH && res_unk_ff) |-> res_dz_ff)
      else $error("unknown opcode without divide-by-zero flag");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != sma_pkg::ST_IDLE))
      else $error("sequencer stayed idle after taking an item");

   a_step_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sma_pkg::ST_MUL || state_ff == sma_pkg::ST_DIV)
      |-> (cnt_ff <= CntBits'(M - 1)))
      else $error("iteration counter ran past the last step");

endmodule

FILE: src/sma_addsub.sv
// ----------------------------------------------------------------------------
// Shared adder/subtractor
// One adder used by every arithmetic step; the top bit is the carry out,
// which on a subtract means the first operand was not below the second.
// ----------------------------------------------------------------------------
module sma_addsub #(
   parameter int Width = sma_pkg::MAGNITUDE_BITS + 1
) (
   input  logic [Width-1:0] op_a,
   input  logic [Width-1:0] op_b,
   input  logic             subtract,
   output logic [Width:0]   sum
);

   logic [Width-1:0] op_b_eff;

   assign op_b_eff = subtract ? ~op_b : op_b;
   assign sum = {1'b0, op_a} + {1'b0, op_b_eff} + (Width+1)'(subtract);

endmodule
